@@ rtl/ieq_pkg.sv @@
// ----------------------------------------------------------------------------
// ieq_pkg
// shared widths, codes, state encoding and device table entry layout
// ----------------------------------------------------------------------------
package ieq_pkg;

  localparam int DEVICE_COUNT_DEF = 32;
  localparam int QUEUE_DEPTH_DEF  = 64;

  localparam int ACT_W  = 2;
  localparam int DEV_W  = 5;
  localparam int WORD_W = 32;
  localparam int SUM_W  = 48;
  localparam int QCNT_W = 7;
  localparam int STAT_W = 2;
  localparam int SCAN_STEPS = 32;

  localparam logic [ACT_W-1:0] ACT_POST      = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INTERRUPT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SERVICE   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_POST     = 6'b000010,
    ST_SCAN     = 6'b000100,
    ST_DRAIN    = 6'b001000,
    ST_SRV_FIFO = 6'b010000,
    ST_SRV_DEV  = 6'b100000
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] id;
    logic [WORD_W-1:0] ev_time;
    logic [WORD_W-1:0] expected;
  } dev_entry_t;

endpackage

@@ rtl/interrupt_event_queue_accounting.sv @@
// ----------------------------------------------------------------------------
// interrupt_event_queue_accounting
// per-device latest event table, pending device fifo and event accounting
//
//   channel   handshake          payload
//   item in   start / busy       action device event_id event_time
//                                device_flags now_tick
//   result    done (one cycle)   status served_device served_event_id
//                                queue_count totals sums highest_device
//
// interrupt runs a 32-step flag scan, with one device table read and one
// fifo push on each step whose flag is set while the fifo is not full,
// then one drain step; post: table read, write back; service: fifo read,
// table read, write back; other items and empty-queue service end in idle
// done lasts one cycle and cannot be held off; busy is low in that cycle, so
// the next transfer may start there
// reset is synchronous; the device table reads as zero until written
// ----------------------------------------------------------------------------
module interrupt_event_queue_accounting #(
  parameter int DEVICE_COUNT = ieq_pkg::DEVICE_COUNT_DEF,
  parameter int QUEUE_DEPTH  = ieq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ieq_pkg::ACT_W-1:0]     action,
  input  logic [ieq_pkg::DEV_W-1:0]     device,
  input  logic [ieq_pkg::WORD_W-1:0]    event_id,
  input  logic [ieq_pkg::WORD_W-1:0]    event_time,
  input  logic [ieq_pkg::WORD_W-1:0]    device_flags,
  input  logic [ieq_pkg::WORD_W-1:0]    now_tick,
  output logic                          done,
  output logic [ieq_pkg::STAT_W-1:0]    status,
  output logic [ieq_pkg::DEV_W-1:0]     served_device,
  output logic [ieq_pkg::WORD_W-1:0]    served_event_id,
  output logic [ieq_pkg::QCNT_W-1:0]    queue_count,
  output logic [ieq_pkg::WORD_W-1:0]    missed_total,
  output logic [ieq_pkg::WORD_W-1:0]    serviced_total,
  output logic [ieq_pkg::WORD_W-1:0]    generated_total,
  output logic [ieq_pkg::SUM_W-1:0]     response_sum,
  output logic [ieq_pkg::SUM_W-1:0]     turnaround_sum,
  output logic [ieq_pkg::DEV_W-1:0]     highest_device
);

  import ieq_pkg::*;

  localparam int DEV_AW = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int QAW    = $clog2(QUEUE_DEPTH);
  localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W  = $bits(dev_entry_t);
  localparam int SCAN_W = $clog2(SCAN_STEPS);

  state_t state;

  // latched item
  logic [DEV_W-1:0]  dev_in;
  logic [WORD_W-1:0] id_in;
  logic [WORD_W-1:0] time_in;
  logic [WORD_W-1:0] flags_in;
  logic [WORD_W-1:0] now_in;

  // fifo control
  logic [QAW-1:0] head;
  logic [QAW-1:0] tail;
  logic [QCW-1:0] qcount;
  logic           full;

  // scan
  logic [SCAN_W-1:0] scan_n;
  logic              scan_hit;
  logic              push;
  logic              acc_v;
  logic              ovf;
  logic [DEV_W-1:0]  srv_dev;

  // device table
  logic [DEVICE_COUNT-1:0] dev_valid;
  logic                    dev_rd_valid;
  logic                    dev_we;
  logic                    dev_re;
  logic [DEV_AW-1:0]       dev_waddr;
  logic [DEV_AW-1:0]       dev_raddr;
  dev_entry_t              dev_wdata;
  logic [ENT_W-1:0]        dev_rdata;
  dev_entry_t              dev_rd;

  // pending device fifo
  logic              fifo_we;
  logic              fifo_re;
  logic [DEV_W-1:0]  fifo_rdata;

  // accounting
  logic [WORD_W-1:0] resp_diff;
  logic [SUM_W:0]    resp_add;
  logic [SUM_W-1:0]  response_sum_next;
  logic [WORD_W-1:0] turn_diff;
  logic [SUM_W:0]    turn_add;
  logic [SUM_W-1:0]  turnaround_sum_next;
  logic [WORD_W-1:0] skip;
  logic [WORD_W:0]   miss_add;
  logic [WORD_W-1:0] missed_total_next;
  logic [WORD_W-1:0] serviced_total_next;
  logic [WORD_W-1:0] generated_total_next;
  logic              accept;

  ieq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEVICE_COUNT)
  ) u_dev_ram (
    .clk   (clk),
    .we    (dev_we),
    .waddr (dev_waddr),
    .wdata (dev_wdata),
    .re    (dev_re),
    .raddr (dev_raddr),
    .rdata (dev_rdata)
  );

  ieq_ram #(
    .WIDTH (DEV_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (tail),
    .wdata (DEV_W'(scan_n)),
    .re    (fifo_re),
    .raddr (head),
    .rdata (fifo_rdata)
  );

  assign busy        = (state != ST_IDLE);
  assign accept      = start && !busy;
  assign full        = (qcount == QCW'(QUEUE_DEPTH));
  assign queue_count = QCNT_W'(qcount);
  assign dev_rd      = dev_rd_valid ? dev_entry_t'(dev_rdata) : '0;

  assign scan_hit = flags_in[scan_n] && ({1'b0, scan_n} < (SCAN_W + 1)'(DEVICE_COUNT));
  assign push     = (state == ST_SCAN) && scan_hit && !full;

  // ram control
  always_comb begin
    dev_re    = 1'b0;
    dev_raddr = '0;
    dev_we    = 1'b0;
    dev_waddr = '0;
    dev_wdata = '0;
    fifo_we   = 1'b0;
    fifo_re   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && action == ACT_POST &&
            {1'b0, device} < (DEV_W + 1)'(DEVICE_COUNT)) begin
          dev_re    = 1'b1;
          dev_raddr = device[DEV_AW-1:0];
        end
        if (accept && action == ACT_SERVICE && qcount != '0) begin
          fifo_re = 1'b1;
        end
      end
      ST_POST: begin
        dev_we    = 1'b1;
        dev_waddr = dev_in[DEV_AW-1:0];
        dev_wdata = '{id: id_in, ev_time: time_in, expected: dev_rd.expected};
      end
      ST_SCAN: begin
        if (push) begin
          fifo_we   = 1'b1;
          dev_re    = 1'b1;
          dev_raddr = scan_n[DEV_AW-1:0];
        end
      end
      ST_SRV_FIFO: begin
        dev_re    = 1'b1;
        dev_raddr = fifo_rdata[DEV_AW-1:0];
      end
      ST_SRV_DEV: begin
        dev_we    = 1'b1;
        dev_waddr = srv_dev[DEV_AW-1:0];
        dev_wdata = '{id: dev_rd.id, ev_time: dev_rd.ev_time,
                      expected: dev_rd.id + WORD_W'(1)};
      end
      default: begin
      end
    endcase
  end

  // saturating accounting
  always_comb begin
    resp_diff         = now_in - dev_rd.ev_time;
    resp_add          = {1'b0, response_sum} + (SUM_W + 1)'(resp_diff);
    response_sum_next = resp_add[SUM_W] ? '1 : resp_add[SUM_W-1:0];

    turn_diff           = now_in - dev_rd.ev_time;
    turn_add            = {1'b0, turnaround_sum} + (SUM_W + 1)'(turn_diff);
    turnaround_sum_next = turn_add[SUM_W] ? '1 : turn_add[SUM_W-1:0];

    skip     = (dev_rd.id > dev_rd.expected) ? (dev_rd.id - dev_rd.expected) : '0;
    miss_add = {1'b0, missed_total} + (WORD_W + 1)'(skip);
    missed_total_next = miss_add[WORD_W] ? '1 : miss_add[WORD_W-1:0];

    serviced_total_next  = (serviced_total == '1) ? serviced_total
                                                   : serviced_total + WORD_W'(1);
    generated_total_next = (generated_total == '1) ? generated_total
                                                    : generated_total + WORD_W'(1);
  end

  // payload and read tracking
  always_ff @(posedge clk) begin
    if (accept) begin
      dev_in   <= device;
      id_in    <= event_id;
      time_in  <= event_time;
      flags_in <= device_flags;
      now_in   <= now_tick;
    end
    if (dev_re) begin
      dev_rd_valid <= dev_valid[dev_raddr];
    end
    if (state == ST_SRV_FIFO) begin
      srv_dev <= fifo_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      done            <= 1'b0;
      head            <= '0;
      tail            <= '0;
      qcount          <= '0;
      scan_n          <= '0;
      acc_v           <= 1'b0;
      ovf             <= 1'b0;
      dev_valid       <= '0;
      missed_total    <= '0;
      serviced_total  <= '0;
      generated_total <= '0;
      response_sum    <= '0;
      turnaround_sum  <= '0;
      highest_device  <= '0;
      status          <= STAT_OK;
      served_device   <= '0;
      served_event_id <= '0;
    end else begin
      done  <= 1'b0;
      acc_v <= push;
      if (dev_we) begin
        dev_valid[dev_waddr] <= 1'b1;
      end
      if (acc_v) begin
        response_sum <= response_sum_next;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            status          <= STAT_OK;
            served_device   <= '0;
            served_event_id <= '0;
            case (action)
              ACT_POST: begin
                if ({1'b0, device} < (DEV_W + 1)'(DEVICE_COUNT)) begin
                  state <= ST_POST;
                end else begin
                  done <= 1'b1;
                end
              end
              ACT_INTERRUPT: begin
                generated_total <= generated_total_next;
                scan_n          <= '0;
                ovf             <= 1'b0;
                state           <= ST_SCAN;
              end
              ACT_SERVICE: begin
                if (qcount == '0) begin
                  status <= STAT_EMPTY;
                  done   <= 1'b1;
                end else begin
                  head   <= (head == QAW'(QUEUE_DEPTH - 1)) ? '0 : head + QAW'(1);
                  qcount <= qcount - QCW'(1);
                  state  <= ST_SRV_FIFO;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_POST: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (push) begin
            tail   <= (tail == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail + QAW'(1);
            qcount <= qcount + QCW'(1);
          end
          if (scan_hit && full) begin
            ovf <= 1'b1;
          end
          scan_n <= scan_n + SCAN_W'(1);
          if (scan_n == SCAN_W'(SCAN_STEPS - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          status <= ovf ? STAT_OVERFLOW : STAT_OK;
          done   <= 1'b1;
          state  <= ST_IDLE;
        end
        ST_SRV_FIFO: begin
          state <= ST_SRV_DEV;
        end
        ST_SRV_DEV: begin
          served_device   <= srv_dev;
          served_event_id <= dev_rd.id;
          missed_total    <= missed_total_next;
          serviced_total  <= serviced_total_next;
          turnaround_sum  <= turnaround_sum_next;
          if (srv_dev > highest_device) begin
            highest_device <= srv_dev;
          end
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_qcount_bound: assert property (@(posedge clk) disable iff (rst)
    qcount <= QCW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_dev_ports: assert property (@(posedge clk) disable iff (rst)
    !(dev_we && dev_re))
    else $error("device table read and write in one cycle");

  a_fifo_ports: assert property (@(posedge clk) disable iff (rst)
    !(fifo_we && fifo_re))
    else $error("fifo push and pop in one cycle");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(accept)))
    else $error("result without an item in progress");

  a_scan_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |->
      ($past(state) == ST_SCAN && $past(scan_n) == SCAN_W'(SCAN_STEPS - 1)))
    else $error("drain entered before scan finished");

endmodule

@@ rtl/ieq_ram.sv @@
// ----------------------------------------------------------------------------
// ieq_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module ieq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
